// ----- design/cst_pkg.sv -----
package cst_pkg;

  localparam int STACK_DEPTH_DEF  = 256;
  localparam int REPEAT_LIMIT_DEF = 1024;

  localparam int ADDR_W    = 64;
  localparam int REPEATS_W = 11;
  localparam int DEPTH_W   = 9;

  typedef enum logic {
    CMD_ENTER = 1'b0,
    CMD_EXIT  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DEPTH_OVF = 2'd1,
    ST_REC_OVF   = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] func_addr;
    logic [ADDR_W-1:0] site_addr;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [ADDR_W-1:0]    top_func;
    logic [ADDR_W-1:0]    top_site;
    logic [REPEATS_W-1:0] top_repeats;
    logic [DEPTH_W-1:0]   stack_depth;
    logic                 is_empty;
  } out_item_t;

endpackage

// ----- design/call_stack_tracker_with_repeat_count.sv -----
// Call stack tracker with repeat counts.
// Input channel (in_valid/in_ready/in_data) takes one enter or exit event per
// beat. An enter that matches the top (function, site) pair raises its repeat
// count up to REPEAT_LIMIT; any other enter pushes a new entry while there is
// room. An exit lowers the top count and pops the entry when the count runs
// out. Each event yields exactly one result beat on the output channel
// (out_valid/out_ready/out_data) with a status, the top entry after the event
// and the stack depth. The top entry lives in registers; the entries below it
// live in one stack memory. The result is registered on acceptance, except for
// an exit that pops an entry and exposes a stored one: it passes through S_FILL,
// since that entry comes back through the registered read of the stack memory,
// and no new event is taken in S_FILL.
// Reset empties the stack (depth zero); the memory itself is not cleared.
// The result is held in an output register; while the receiver stalls, that
// beat stays put and in_ready is low until it is taken.
module call_stack_tracker_with_repeat_count #(
  parameter int STACK_DEPTH  = cst_pkg::STACK_DEPTH_DEF,
  parameter int REPEAT_LIMIT = cst_pkg::REPEAT_LIMIT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cst_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cst_pkg::out_item_t  out_data
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(REPEAT_LIMIT + 1);
  localparam int MW = 2 * cst_pkg::ADDR_W + CW;

  typedef enum logic {
    S_IDLE,
    S_FILL
  } state_t;

  state_t                      state_r, state_nxt;
  logic [DW-1:0]               depth_r, depth_nxt;
  logic [cst_pkg::ADDR_W-1:0]  top_func_r, top_func_nxt;
  logic [cst_pkg::ADDR_W-1:0]  top_site_r, top_site_nxt;
  logic [CW-1:0]               top_cnt_r, top_cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  cst_pkg::out_item_t          out_data_r, out_data_nxt;

  logic                        accept;
  logic                        top_valid;
  logic                        match;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [AW-1:0]               ram_raddr;
  logic [MW-1:0]               ram_wdata;
  logic [MW-1:0]               ram_rdata;
  logic [DW-1:0]               depth_dec;
  logic [DW-1:0]               depth_dec2;
  cst_pkg::status_t            status;

  // Result fields built from the top entry after the event.
  logic [cst_pkg::ADDR_W-1:0]  res_func;
  logic [cst_pkg::ADDR_W-1:0]  res_site;
  logic [CW-1:0]               res_cnt;
  logic [DW-1:0]               res_depth;
  logic [CW+cst_pkg::REPEATS_W-1:0] res_cnt_ext;
  logic [DW+cst_pkg::DEPTH_W-1:0]   res_depth_ext;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign top_valid  = (depth_r != '0);
  assign match      = top_valid && (in_data.func_addr == top_func_r)
                      && (in_data.site_addr == top_site_r);
  assign depth_dec  = depth_r - DW'(1);
  assign depth_dec2 = depth_r - DW'(2);

  assign ram_waddr = depth_dec[AW-1:0];
  assign ram_raddr = depth_dec2[AW-1:0];
  assign ram_wdata = {top_func_r, top_site_r, top_cnt_r};

  cst_ram #(
    .WIDTH (MW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    depth_nxt    = depth_r;
    top_func_nxt = top_func_r;
    top_site_nxt = top_site_r;
    top_cnt_nxt  = top_cnt_r;
    ram_we       = 1'b0;
    status       = cst_pkg::ST_OK;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.cmd)
            cst_pkg::CMD_ENTER: begin
              if (match) begin
                if (top_cnt_r >= CW'(REPEAT_LIMIT)) begin
                  status = cst_pkg::ST_REC_OVF;
                end else begin
                  top_cnt_nxt = top_cnt_r + CW'(1);
                end
              end else if (depth_r == DW'(STACK_DEPTH)) begin
                status = cst_pkg::ST_DEPTH_OVF;
              end else begin
                // The old top moves down into the memory.
                ram_we       = top_valid;
                top_func_nxt = in_data.func_addr;
                top_site_nxt = in_data.site_addr;
                top_cnt_nxt  = CW'(1);
                depth_nxt    = depth_r + DW'(1);
              end
            end
            cst_pkg::CMD_EXIT: begin
              if (!top_valid) begin
                status = cst_pkg::ST_UNDERFLOW;
              end else if (top_cnt_r <= CW'(1)) begin
                depth_nxt = depth_dec;
                // With an entry left below, its read is in flight; the result
                // waits for it in S_FILL.
                if (depth_dec != '0) begin
                  state_nxt = S_FILL;
                end
              end else begin
                top_cnt_nxt = top_cnt_r - CW'(1);
              end
            end
            default: begin
              status = cst_pkg::ST_OK;
            end
          endcase
          out_valid_nxt = (state_nxt == S_IDLE);
        end
      end
      S_FILL: begin
        {top_func_nxt, top_site_nxt, top_cnt_nxt} = ram_rdata;
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_depth = depth_nxt;
    if (depth_nxt == '0) begin
      res_func = '0;
      res_site = '0;
      res_cnt  = '0;
    end else begin
      res_func = top_func_nxt;
      res_site = top_site_nxt;
      res_cnt  = top_cnt_nxt;
    end
    res_cnt_ext   = {{cst_pkg::REPEATS_W{1'b0}}, res_cnt};
    res_depth_ext = {{cst_pkg::DEPTH_W{1'b0}}, res_depth};

    out_data_nxt.status      = status;
    out_data_nxt.top_func    = res_func;
    out_data_nxt.top_site    = res_site;
    out_data_nxt.top_repeats = res_cnt_ext[cst_pkg::REPEATS_W-1:0];
    out_data_nxt.stack_depth = res_depth_ext[cst_pkg::DEPTH_W-1:0];
    out_data_nxt.is_empty    = (res_depth == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
      top_func_r  <= top_func_nxt;
      top_site_r  <= top_site_nxt;
      top_cnt_r   <= top_cnt_nxt;
      if ((state_r == S_IDLE && accept && state_nxt == S_IDLE) || state_r == S_FILL) begin
        out_data_r <= out_data_nxt;
      end
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_fill_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> !out_valid_r)
    else $error("reload landed while a result beat was pending");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |-> out_data.top_repeats == '0
      && out_data.stack_depth == '0)
    else $error("empty result carries a nonzero entry");

  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.cmd == cst_pkg::CMD_EXIT && depth_r == '0
      |=> out_valid_r && out_data_r.status == cst_pkg::ST_UNDERFLOW)
    else $error("exit on empty stack not reported as underflow");

  a_top_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && depth_r != '0 |-> top_cnt_r != '0)
    else $error("live top entry with zero repeat count");

endmodule

// ----- design/cst_ram.sv -----
module cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- verif/stack_result_checker.sv -----
module stack_result_checker
  import cst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_item_t  out_data,
  output int         mismatch_count,
  output int         results_pending
);

  logic [ADDR_W-1:0] func_mirror   [STACK_DEPTH_DEF];
  logic [ADDR_W-1:0] site_mirror   [STACK_DEPTH_DEF];
  int unsigned       repeat_mirror [STACK_DEPTH_DEF];
  int unsigned       depth_mirror;
  out_item_t         expected_results [$];
  out_item_t         want_item;
  int                beat_index;

  // Applies one event to the mirrored stack and returns the result beat it should produce.
  function automatic out_item_t apply_stack_event(in_item_t ev);
    status_t     st;
    out_item_t   res;
    int unsigned top;
    st  = ST_OK;
    top = depth_mirror - 1;
    if (ev.cmd == CMD_ENTER) begin
      if (depth_mirror > 0 && func_mirror[top] == ev.func_addr &&
          site_mirror[top] == ev.site_addr) begin
        if (repeat_mirror[top] >= REPEAT_LIMIT_DEF) begin
          st = ST_REC_OVF;
        end else begin
          repeat_mirror[top]++;
        end
      end else if (depth_mirror >= STACK_DEPTH_DEF) begin
        st = ST_DEPTH_OVF;
      end else begin
        func_mirror[depth_mirror]   = ev.func_addr;
        site_mirror[depth_mirror]   = ev.site_addr;
        repeat_mirror[depth_mirror] = 1;
        depth_mirror++;
      end
    end else if (depth_mirror == 0) begin
      st = ST_UNDERFLOW;
    end else if (repeat_mirror[top] <= 1) begin
      repeat_mirror[top] = 0;
      depth_mirror--;
    end else begin
      repeat_mirror[top]--;
    end
    res             = '0;
    res.status      = st;
    res.stack_depth = depth_mirror[DEPTH_W-1:0];
    res.is_empty    = (depth_mirror == 0);
    if (depth_mirror > 0) begin
      top             = depth_mirror - 1;
      res.top_func    = func_mirror[top];
      res.top_site    = site_mirror[top];
      res.top_repeats = repeat_mirror[top][REPEATS_W-1:0];
    end
    return res;
  endfunction

  task automatic note_mismatch(string what, out_item_t want, out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("result beat %0d, %s: expected status=%0d func=%h site=%h rep=%0d",
               beat_index, what, want.status, want.top_func, want.top_site,
               want.top_repeats);
      $display("  expected depth=%0d empty=%0b", want.stack_depth, want.is_empty);
      $display("  got status=%0d func=%h site=%h rep=%0d depth=%0d empty=%0b",
               got.status, got.top_func, got.top_site, got.top_repeats,
               got.stack_depth, got.is_empty);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      depth_mirror = 0;
    end else begin
      // A result beat always belongs to an event taken on an earlier edge, so compare first.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_mismatch("no event pending", '0, out_data);
        end else begin
          want_item = expected_results.pop_front();
          if (out_data.status !== want_item.status ||
              out_data.top_func !== want_item.top_func ||
              out_data.top_site !== want_item.top_site ||
              out_data.top_repeats !== want_item.top_repeats ||
              out_data.stack_depth !== want_item.stack_depth ||
              out_data.is_empty !== want_item.is_empty) begin
            note_mismatch("field differs", want_item, out_data);
          end
        end
        beat_index++;
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_stack_event(in_data));
      end
    end
    results_pending = expected_results.size();
  end

endmodule

// ----- verif/tb_call_stack_tracker_with_repeat_count.sv -----
module tb_call_stack_tracker_with_repeat_count;
  import cst_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 800;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int   mismatch_count;
  int   results_pending;
  int   cycle_count;
  int   events_sent;
  bit   quiet;
  logic [ADDR_W-1:0] addr_pool [8];

  call_stack_tracker_with_repeat_count u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  stack_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  // Reusing a small pool makes partial matches (same function, other site) likely.
  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 3) == 0) return addr_pool[$urandom_range(0, 7)];
    return rand_addr();
  endfunction

  // Called on a rising edge; returns on the edge at which the beat is taken.
  task automatic send_event(cmd_t c, logic [ADDR_W-1:0] f, logic [ADDR_W-1:0] s);
    int gap;
    in_item_t item;
    gap = pick_gap();
    item.cmd       = c;
    item.func_addr = f;
    item.site_addr = s;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    events_sent++;
  endtask

  task automatic send_exit();
    send_event(CMD_EXIT, rand_addr(), rand_addr());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
    @(posedge clk);
  endtask

  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      int hi;
      int g;
      hi = $urandom_range(1, 16);
      out_ready <= 1'b1;
      repeat (hi) @(posedge clk);
      g = pick_gap();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  initial begin
    logic [ADDR_W-1:0] pat_a;
    logic [ADDR_W-1:0] last_f;
    logic [ADDR_W-1:0] last_s;
    logic [ADDR_W-1:0] f;
    logic [ADDR_W-1:0] s;
    int kind;
    int total;
    int n;
    int random_start;

    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    quiet       = 1'b0;
    events_sent = 0;
    pat_a       = 64'hA5A5_A5A5_A5A5_A5A5;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < 8; i++) addr_pool[i] = rand_addr();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: underflow on an empty stack, push from empty, matching and
    // partially matching enters, extreme addresses, and exits that ignore addresses.
    send_exit();
    send_event(CMD_ENTER, '0, '0);
    send_event(CMD_ENTER, '0, '0);
    send_event(CMD_ENTER, '0, '1);
    send_event(CMD_ENTER, '1, '1);
    send_event(CMD_ENTER, '1, '0);
    send_event(CMD_ENTER, '0, '0);
    repeat (5) send_exit();
    send_event(CMD_EXIT, '1, '1);
    send_exit();
    send_event(CMD_ENTER, pat_a, ~pat_a);
    send_event(CMD_ENTER, pat_a, ~pat_a);
    send_event(CMD_ENTER, ~pat_a, pat_a);
    repeat (4) send_exit();
    drain();

    // Fill the stack from empty: overflow on non-matching enters, while a
    // matching enter on the full stack still raises the top count.
    for (int i = 0; i < STACK_DEPTH_DEF; i++) begin
      last_f = rand_addr();
      last_s = rand_addr();
      send_event(CMD_ENTER, last_f, last_s);
    end
    repeat (4) send_event(CMD_ENTER, pick_addr(), pick_addr());
    send_event(CMD_ENTER, last_f, last_s);
    send_event(CMD_ENTER, last_f, ~last_s);
    repeat (STACK_DEPTH_DEF + 4) send_exit();

    // Recursion up to the cap and beyond, then unwind through underflow.
    quiet = 1'b1;
    f = pick_addr();
    s = pick_addr();
    repeat (REPEAT_LIMIT_DEF + 2) send_event(CMD_ENTER, f, s);
    quiet = 1'b0;
    repeat (REPEAT_LIMIT_DEF + 1) send_exit();
    drain();

    random_start = events_sent;
    while (events_sent - random_start < RANDOM_ITEMS) begin
      kind  = $urandom_range(0, 99);
      quiet = ($urandom_range(0, 5) == 0);
      if (kind < 40 || kind >= 95) begin
        if (kind >= 95) drain();
        total = 0;
        repeat ($urandom_range(1, 12)) begin
          f = pick_addr();
          s = pick_addr();
          n = $urandom_range(1, 4);
          repeat (n) send_event(CMD_ENTER, f, s);
          total += n;
        end
        n = total + $urandom_range(0, 3) - 2;
        repeat ((n < 0) ? 0 : n) send_exit();
      end else if (kind < 60) begin
        f = pick_addr();
        s = pick_addr();
        n = $urandom_range(2, 30);
        repeat (n) send_event(CMD_ENTER, f, s);
        repeat (n) send_exit();
      end else if (kind < 75) begin
        repeat ($urandom_range(10, 30)) begin
          if ($urandom_range(0, 1) == 0) send_event(CMD_ENTER, addr_pool[$urandom_range(0, 7)],
                                                     addr_pool[$urandom_range(0, 7)]);
          else send_exit();
        end
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 6)) send_exit();
      end else begin
        repeat ($urandom_range(5, 15)) begin
          send_event(cmd_t'($urandom_range(0, 1)), rand_addr(), rand_addr());
        end
      end
    end
    quiet = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
